// ----- hdl/stbs_pkg.sv -----
package stbs_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_LOAD,
		DP_CLEAR,
		DP_INS_INIT,
		DP_INS_SHIFT,
		DP_INS_PLACE,
		DP_SRCH_START,
		DP_SRCH_STEP
	} dp_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CMP,
		S_INS_LAST,
		S_SRCH,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic       res_set;
		logic [1:0] res_status;
		logic       res_found;
		logic       out_load;
	} dp_ctrl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       count_zero;
		logic       idx_le1;
		logic       gt;
		logic       eq;
		logic       step_empty;
	} dp_status_t;

endpackage

// ----- hdl/stbs_dp.sv -----
module stbs_dp #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stbs_pkg::dp_ctrl_t    ctrl,
	output stbs_pkg::dp_status_t  stat,
	input  logic [1:0]            cmd,
	input  logic signed [31:0]    value,
	output logic [1:0]            status,
	output logic [7:0]            position
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] TWO = CW'(2);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic signed [31:0] mem [TABLE_DEPTH];

	logic [1:0]         cmd_q;
	logic signed [31:0] key_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hx_q;
	logic [CW-1:0]      mid_q;
	logic signed [31:0] rdata_q;
	logic [1:0]         res_status_q;
	logic [7:0]         res_pos_q;
	logic [1:0]         status_q;
	logic [7:0]         position_q;

	logic [CW-1:0] nlo, nhx, nmid, smid;
	logic [CW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic signed [31:0] wdata;

	// Next search range after a miss; the upper bound is held exclusive.
	always_comb begin
		nlo  = stat.gt ? lo_q : mid_q + ONE;
		nhx  = stat.gt ? mid_q : hx_q;
		nmid = nlo + ((nhx - ONE - nlo) >> 1);
		smid = (count_q - ONE) >> 1;
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.full       = (count_q == DEPTH_C);
		stat.count_zero = (count_q == '0);
		stat.idx_le1    = (idx_q <= ONE);
		stat.gt         = (rdata_q > key_q);
		stat.eq         = (rdata_q == key_q);
		stat.step_empty = (nlo >= nhx);
	end

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = key_q;
		case (ctrl.op)
			DP_INS_INIT:   raddr = count_q - ONE;
			DP_INS_SHIFT: begin
				raddr = idx_q - TWO;
				we    = 1'b1;
				wdata = rdata_q;
			end
			DP_INS_PLACE:  we = 1'b1;
			DP_SRCH_START: raddr = smid;
			DP_SRCH_STEP:  raddr = nmid;
			default:       raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctrl.op)
				DP_CLEAR:     count_q <= '0;
				DP_INS_PLACE: count_q <= count_q + ONE;
				default:      count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			DP_LOAD: begin
				cmd_q <= cmd;
				key_q <= value;
			end
			DP_INS_INIT:  idx_q <= count_q;
			DP_INS_SHIFT: idx_q <= idx_q - ONE;
			DP_SRCH_START: begin
				lo_q  <= '0;
				hx_q  <= count_q;
				mid_q <= smid;
			end
			DP_SRCH_STEP: begin
				lo_q  <= nlo;
				hx_q  <= nhx;
				mid_q <= nmid;
			end
			default: begin
			end
		endcase
		if (ctrl.res_set) begin
			res_status_q <= ctrl.res_status;
			res_pos_q    <= ctrl.res_found ? 8'(mid_q) : 8'd0;
		end
		if (ctrl.out_load) begin
			status_q   <= res_status_q;
			position_q <= res_pos_q;
		end
	end

	assign status   = status_q;
	assign position = position_q;

endmodule

// ----- hdl/stbs_ctrl.sv -----
module stbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  stbs_pkg::dp_status_t stat,
	output stbs_pkg::dp_ctrl_t   ctrl
);
	import stbs_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		ctrl     = '0;
		ctrl.op  = DP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.op = DP_LOAD;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ctrl.res_set    = 1'b1;
				ctrl.res_status = STATUS_DONE;
				state_n         = S_RESP;
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							ctrl.res_status = STATUS_FULL;
						end else begin
							ctrl.res_set = 1'b0;
							ctrl.op      = DP_INS_INIT;
							state_n      = stat.count_zero ? S_INS_LAST : S_INS_CMP;
						end
					end
					CMD_SEARCH: begin
						if (stat.count_zero) begin
							ctrl.res_status = STATUS_NOT_FOUND;
						end else begin
							ctrl.res_set = 1'b0;
							ctrl.op      = DP_SRCH_START;
							state_n      = S_SRCH;
						end
					end
					CMD_CLEAR: ctrl.op = DP_CLEAR;
					default:   ctrl.op = DP_NONE;
				endcase
			end
			S_INS_CMP: begin
				// Larger entries move up one place until the slot for the new value opens.
				if (stat.gt) begin
					ctrl.op = DP_INS_SHIFT;
					if (stat.idx_le1) begin
						state_n = S_INS_LAST;
					end
				end else begin
					ctrl.op         = DP_INS_PLACE;
					ctrl.res_set    = 1'b1;
					ctrl.res_status = STATUS_DONE;
					state_n         = S_RESP;
				end
			end
			S_INS_LAST: begin
				ctrl.op         = DP_INS_PLACE;
				ctrl.res_set    = 1'b1;
				ctrl.res_status = STATUS_DONE;
				state_n         = S_RESP;
			end
			S_SRCH: begin
				if (stat.eq) begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = STATUS_DONE;
					ctrl.res_found  = 1'b1;
					state_n         = S_RESP;
				end else if (stat.step_empty) begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = STATUS_NOT_FOUND;
					state_n         = S_RESP;
				end else begin
					ctrl.op = DP_SRCH_STEP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					ctrl.out_load = 1'b1;
					state_n       = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// Sorted table of signed 32-bit values with insert, binary search and clear.
// Input channel: in_valid/in_ready with cmd (insert, search, clear) and value.
// Output channel: out_valid/out_ready with status and position, one result
// transaction for every input transaction, in order.
// One transaction is worked on at a time, through a controller and a datapath
// around a table memory with one registered read port and one write port.
// in_ready rises again in the same cycle that out_valid rises.
// Clear, unused commands, a refused insert into a full table and a search of
// an empty table go from the dispatch state straight to the response state.
// A search makes p probes, where p is at most clog2(TABLE_DEPTH) + 1, and each
// probe is one memory read and compare.
// An insert moves each of the k larger entries up one place, one memory read
// and write per entry moved, and then writes the new value into the open slot.
// Reset empties the table at once by clearing the entry count; no pass over
// the memory is made. If the receiver stalls, the finished result waits in
// the output register while one more transaction is accepted and worked on.
// That second result is then held back, with in_ready low, until the first
// has been taken.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [7:0]         position
);
	import stbs_pkg::*;

	dp_ctrl_t   ctrl;
	dp_status_t stat;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.cmd      (cmd),
		.value    (value),
		.status   (status),
		.position (position)
	);

endmodule
